/* rtl/can_rxf_pkg.sv */
// Shared types and constants of the CAN receive filter with per-client frame queues.
// Holds the sizing constants, the command and frame records and the kind and status codes.
// No dependencies.
`default_nettype none

package can_rxf_pkg;

	// Sizing of the block.
	localparam int NUM_CLIENTS = 4;
	localparam int QUEUE_DEPTH = 16;

	localparam int CL_W  = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Fixed field widths.
	localparam int NUM_FILTERS = 4;
	localparam int KIND_W      = 2;
	localparam int CLIENT_W    = 2;
	localparam int ID_W        = 29;
	localparam int DLC_W       = 4;
	localparam int DATA_W      = 64;
	localparam int STATUS_W    = 2;
	localparam int MASK_W      = 4;
	localparam int LEVEL_W     = 5;
	localparam int LIM_W       = 5;
	localparam int LIMITS_W    = 20;
	localparam int FW_W        = 63;

	// Configuration port.
	localparam int APB_DW   = 64;
	localparam int APB_AW   = 6;
	localparam int REG_IDX_W = 3;

	localparam logic [LIMITS_W-1:0] LIMITS_RESET = 20'd541200;

	// Bit positions inside a filter word.
	localparam int FW_MASK_LSB = 29;
	localparam int FW_EXT_MUST = 58;
	localparam int FW_EXT      = 59;
	localparam int FW_RTR_MUST = 60;
	localparam int FW_RTR      = 61;
	localparam int FW_ENABLE   = 62;

	// Command queue between front and back.
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_AW    = 1;

	typedef enum logic [KIND_W-1:0] {
		KIND_FRAME  = 2'd0,
		KIND_POP    = 2'd1,
		KIND_CLEAR  = 2'd2,
		KIND_STATUS = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 2'd0,
		ST_EMPTY      = 2'd1,
		ST_BAD_CLIENT = 2'd2,
		ST_OVERFLOW   = 2'd3
	} status_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_FILTER0 = 3'd0,
		REG_FILTER1 = 3'd1,
		REG_FILTER2 = 3'd2,
		REG_FILTER3 = 3'd3,
		REG_LIMITS  = 3'd4
	} reg_idx_t;

	typedef logic [NUM_FILTERS-1:0][FW_W-1:0] fw_bank_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic              ext;
		logic              rtr;
		logic [DLC_W-1:0]  dlc;
		logic [DATA_W-1:0] data;
	} frame_t;

	// One classified request on its way to the back end.
	typedef struct packed {
		kind_t                  kind;
		logic [CLIENT_W-1:0]    client;
		logic                   in_range;
		logic                   client_ok;
		logic [NUM_CLIENTS-1:0] pass;
		frame_t                 frame;
	} cmd_t;

	typedef struct packed {
		logic                wr;
		logic [LIMITS_W-1:0] value;
	} limits_upd_t;

endpackage

`default_nettype wire

/* rtl/can_rx_filter_multi_fifo.sv */
// Top level of the CAN receive filter with one frame queue per client.
// Connects the register file, filter front end, command queue and queue back end (can_rxf_pkg).
//
// Requests enter through a queue-style port (push/full) and results leave through another
// (pop/empty), one result per request, in request order. A frame request is compared
// against the filter word of every client: it passes when the client is enabled, the
// identifier ANDed with the mask equals the code, and the extended and remote flags
// agree wherever the filter demands it. Each passing client stores the frame in its own
// queue unless the queue has reached its limit, in which case the frame is dropped for
// that client and its overflow flag is set; a successful store or a status request clears
// the flag. Pop, clear and status requests address one client; a disabled client answers
// bad client. The filter words and the limits are written over the APB-style port, eight
// bytes per register; the user must write them only while the block is idle, which the
// block itself does not enforce. Writing a lower limit trims each queue to it, keeping
// its oldest frames. Timing: the filter front end classifies a request in the cycle it is
// accepted and parks it in a two-entry command queue at the accepting edge; the back end
// takes one command per cycle while its result stages can advance, updating fill counts
// and pointers and writing or reading the per-client frame memories, and the result
// reaches the output ports through the execute stage, with its registered memory read,
// and then the output register. With the result side popping every cycle the block
// sustains one request per cycle; the execute stage, which owns all queue state, sets
// that rate. The front end keeps accepting while a result waits, until the command queue
// and the two result stages are full. No memory clearing pass is needed after reset.
`default_nettype none

module can_rx_filter_multi_fifo (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration port.
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [can_rxf_pkg::APB_AW-1:0]    paddr,
	input  logic [can_rxf_pkg::APB_DW-1:0]    pwdata,
	output logic [can_rxf_pkg::APB_DW-1:0]    prdata,
	output logic                              pready,
	// Request side.
	input  logic                              push,
	output logic                              full,
	input  logic [can_rxf_pkg::KIND_W-1:0]    kind,
	input  logic [can_rxf_pkg::CLIENT_W-1:0]  client,
	input  logic [can_rxf_pkg::ID_W-1:0]      frame_id,
	input  logic                              frame_ext,
	input  logic                              frame_rtr,
	input  logic [can_rxf_pkg::DLC_W-1:0]     frame_dlc,
	input  logic [can_rxf_pkg::DATA_W-1:0]    frame_data,
	// Result side.
	output logic                              empty,
	input  logic                              pop,
	output logic [can_rxf_pkg::STATUS_W-1:0]  status,
	output logic [can_rxf_pkg::MASK_W-1:0]    accepted_mask,
	output logic [can_rxf_pkg::MASK_W-1:0]    overflow_mask,
	output logic [can_rxf_pkg::ID_W-1:0]      out_id,
	output logic                              out_ext,
	output logic                              out_rtr,
	output logic [can_rxf_pkg::DLC_W-1:0]     out_dlc,
	output logic [can_rxf_pkg::DATA_W-1:0]    out_data,
	output logic [can_rxf_pkg::LEVEL_W-1:0]   queue_level
);
	import can_rxf_pkg::*;

	fw_bank_t            filters;
	logic [LIMITS_W-1:0] limits;
	limits_upd_t         limits_upd;

	cmd_t front_cmd;
	cmd_t back_cmd;
	logic front_push;
	logic q_full;
	logic q_valid;
	logic q_take;

	// The register file holds the four filter words and the packed queue limits.
	can_rxf_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.filters    (filters),
		.limits     (limits),
		.limits_upd (limits_upd)
	);

	// The front end accepts a request whenever the command queue has room and
	// resolves which clients a received frame is meant for.
	can_rxf_front u_front (
		.filters    (filters),
		.push       (push),
		.full       (full),
		.kind       (kind),
		.client     (client),
		.frame_id   (frame_id),
		.frame_ext  (frame_ext),
		.frame_rtr  (frame_rtr),
		.frame_dlc  (frame_dlc),
		.frame_data (frame_data),
		.q_full     (q_full),
		.cmd_push   (front_push),
		.cmd        (front_cmd)
	);

	can_rxf_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (front_push),
		.wr_cmd (front_cmd),
		.full   (q_full),
		.rd_en  (q_take),
		.rd_cmd (back_cmd),
		.valid  (q_valid)
	);

	// The back end owns all queue state and presents the oldest result.
	can_rxf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (back_cmd),
		.cmd_valid     (q_valid),
		.cmd_take      (q_take),
		.limits        (limits),
		.limits_upd    (limits_upd),
		.empty         (empty),
		.pop           (pop),
		.status        (status),
		.accepted_mask (accepted_mask),
		.overflow_mask (overflow_mask),
		.out_id        (out_id),
		.out_ext       (out_ext),
		.out_rtr       (out_rtr),
		.out_dlc       (out_dlc),
		.out_data      (out_data),
		.queue_level   (queue_level)
	);

endmodule

`default_nettype wire

/* rtl/can_rxf_regs.sv */
// Configuration register file of the CAN receive filter: four filter words and the limits.
// APB-style slave with zero wait states. Depends on can_rxf_pkg.
`default_nettype none

module can_rxf_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [can_rxf_pkg::APB_AW-1:0] paddr,
	input  logic [can_rxf_pkg::APB_DW-1:0] pwdata,
	output logic [can_rxf_pkg::APB_DW-1:0] prdata,
	output logic                           pready,
	output can_rxf_pkg::fw_bank_t          filters,
	output logic [can_rxf_pkg::LIMITS_W-1:0] limits,
	output can_rxf_pkg::limits_upd_t       limits_upd
);
	import can_rxf_pkg::*;

	fw_bank_t              filters_q;
	logic [LIMITS_W-1:0]   limits_q;
	reg_idx_t              idx;
	logic                  wr;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[APB_AW-1:APB_AW-REG_IDX_W]);
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filters_q <= '0;
			limits_q  <= LIMITS_RESET;
		end else if (wr) begin
			case (idx)
				REG_FILTER0: filters_q[0] <= pwdata[FW_W-1:0];
				REG_FILTER1: filters_q[1] <= pwdata[FW_W-1:0];
				REG_FILTER2: filters_q[2] <= pwdata[FW_W-1:0];
				REG_FILTER3: filters_q[3] <= pwdata[FW_W-1:0];
				REG_LIMITS:  limits_q     <= pwdata[LIMITS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_FILTER0: prdata = APB_DW'(filters_q[0]);
			REG_FILTER1: prdata = APB_DW'(filters_q[1]);
			REG_FILTER2: prdata = APB_DW'(filters_q[2]);
			REG_FILTER3: prdata = APB_DW'(filters_q[3]);
			REG_LIMITS:  prdata = APB_DW'(limits_q);
			default:     prdata = '0;
		endcase
	end

	assign filters          = filters_q;
	assign limits           = limits_q;
	// The back end clips its fill counts to the limits being written.
	assign limits_upd.wr    = wr && (idx == REG_LIMITS);
	assign limits_upd.value = pwdata[LIMITS_W-1:0];

endmodule

`default_nettype wire

/* rtl/can_rxf_front.sv */
// Front end of the CAN receive filter: accepts requests and runs the acceptance filters.
// Produces one classified command per request. Depends on can_rxf_pkg.
`default_nettype none

module can_rxf_front (
	input  can_rxf_pkg::fw_bank_t             filters,
	input  logic                              push,
	output logic                              full,
	input  logic [can_rxf_pkg::KIND_W-1:0]    kind,
	input  logic [can_rxf_pkg::CLIENT_W-1:0]  client,
	input  logic [can_rxf_pkg::ID_W-1:0]      frame_id,
	input  logic                              frame_ext,
	input  logic                              frame_rtr,
	input  logic [can_rxf_pkg::DLC_W-1:0]     frame_dlc,
	input  logic [can_rxf_pkg::DATA_W-1:0]    frame_data,
	input  logic                              q_full,
	output logic                              cmd_push,
	output can_rxf_pkg::cmd_t                 cmd
);
	import can_rxf_pkg::*;

	logic [FW_W-1:0] fw_sel;
	logic            in_range;

	assign full     = q_full;
	assign cmd_push = push && !q_full;

	assign in_range = ({1'b0, client} < (CLIENT_W + 1)'(NUM_CLIENTS));
	assign fw_sel   = filters[client];

	always_comb begin
		cmd.kind       = kind_t'(kind);
		cmd.client     = client;
		cmd.in_range   = in_range;
		cmd.client_ok  = in_range && fw_sel[FW_ENABLE];
		cmd.frame.id   = frame_id;
		cmd.frame.ext  = frame_ext;
		cmd.frame.rtr  = frame_rtr;
		cmd.frame.dlc  = frame_dlc;
		cmd.frame.data = frame_data;
		// A client takes the frame when enabled, the masked ID hits its code and the
		// flags agree wherever the filter asks for a match.
		for (int c = 0; c < NUM_CLIENTS; c++) begin
			cmd.pass[c] = filters[c][FW_ENABLE]
				&& ((frame_id & filters[c][FW_MASK_LSB +: ID_W]) == filters[c][ID_W-1:0])
				&& (!filters[c][FW_EXT_MUST] || (filters[c][FW_EXT] == frame_ext))
				&& (!filters[c][FW_RTR_MUST] || (filters[c][FW_RTR] == frame_rtr));
		end
	end

endmodule

`default_nettype wire

/* rtl/can_rxf_cmdq.sv */
// Short command queue that decouples the filter front end from the queue back end.
// Two entries of classified commands. Depends on can_rxf_pkg.
`default_nettype none

module can_rxf_cmdq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  can_rxf_pkg::cmd_t wr_cmd,
	output logic              full,
	input  logic              rd_en,
	output can_rxf_pkg::cmd_t rd_cmd,
	output logic              valid
);
	import can_rxf_pkg::*;

	cmd_t               mem_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0] wptr_q;
	logic [CMDQ_AW-1:0] rptr_q;
	logic [CMDQ_AW:0]   count_q;

	assign full   = (count_q == (CMDQ_AW + 1)'(CMDQ_DEPTH));
	assign valid  = (count_q != '0);
	assign rd_cmd = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd_en) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/can_rxf_back.sv */
// Back end of the CAN receive filter: per-client frame memories, fill counts and pointers.
// Executes one command per cycle while its two-stage result output can advance. Uses can_rxf_pkg.
`default_nettype none

module can_rxf_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  can_rxf_pkg::cmd_t                 cmd,
	input  logic                              cmd_valid,
	output logic                              cmd_take,
	input  logic [can_rxf_pkg::LIMITS_W-1:0]  limits,
	input  can_rxf_pkg::limits_upd_t          limits_upd,
	output logic                              empty,
	input  logic                              pop,
	output logic [can_rxf_pkg::STATUS_W-1:0]  status,
	output logic [can_rxf_pkg::MASK_W-1:0]    accepted_mask,
	output logic [can_rxf_pkg::MASK_W-1:0]    overflow_mask,
	output logic [can_rxf_pkg::ID_W-1:0]      out_id,
	output logic                              out_ext,
	output logic                              out_rtr,
	output logic [can_rxf_pkg::DLC_W-1:0]     out_dlc,
	output logic [can_rxf_pkg::DATA_W-1:0]    out_data,
	output logic [can_rxf_pkg::LEVEL_W-1:0]   queue_level
);
	import can_rxf_pkg::*;

	typedef struct packed {
		status_t                status;
		logic [NUM_CLIENTS-1:0] acc;
		logic [NUM_CLIENTS-1:0] ovf;
		logic [CNT_W-1:0]       level;
		logic                   pop_ok;
		logic [CL_W-1:0]        rd_client;
	} res_t;

	function automatic logic [CNT_W-1:0] limit_of(logic [LIMITS_W-1:0] w, int c);
		logic [LIM_W-1:0] f;
		f = w[LIM_W*c +: LIM_W];
		return (f > LIM_W'(QUEUE_DEPTH)) ? CNT_W'(QUEUE_DEPTH) : CNT_W'(f);
	endfunction

	logic [CNT_W-1:0] fill_q     [NUM_CLIENTS];
	logic [PTR_W-1:0] rp_q       [NUM_CLIENTS];
	logic             ovf_flag_q [NUM_CLIENTS];
	frame_t           rdata_q    [NUM_CLIENTS];

	logic [CNT_W-1:0] fill_step [NUM_CLIENTS];
	logic [PTR_W-1:0] waddr     [NUM_CLIENTS];
	logic [NUM_CLIENTS-1:0] push_c, drop_c, pop_c, clr_c, rdst_c;

	logic            s1_valid_q, s2_valid_q, advance;
	res_t            res_s1, res_nxt, res_s2;
	frame_t          frame_s2;
	logic [CL_W-1:0] cl_idx;
	logic            is_frame;

	assign advance  = s1_valid_q && (!s2_valid_q || pop);
	assign cmd_take = cmd_valid && (!s1_valid_q || advance);
	assign cl_idx   = cmd.client[CL_W-1:0];
	assign is_frame = (cmd.kind == KIND_FRAME);

	// Per-client effect of the command being taken.
	always_comb begin
		logic [CNT_W:0] sum;
		logic           sel;
		logic           at_limit;
		for (int c = 0; c < NUM_CLIENTS; c++) begin
			sel      = cmd.client_ok && (cl_idx == CL_W'(c));
			at_limit = (fill_q[c] >= limit_of(limits, c));
			push_c[c] = cmd_take && is_frame && cmd.pass[c] && !at_limit;
			drop_c[c] = cmd_take && is_frame && cmd.pass[c] && at_limit;
			pop_c[c]  = cmd_take && sel && (cmd.kind == KIND_POP) && (fill_q[c] != '0);
			clr_c[c]  = cmd_take && sel && (cmd.kind == KIND_CLEAR);
			rdst_c[c] = cmd_take && sel && (cmd.kind == KIND_STATUS);

			// The fill stays below the depth whenever a push happens, so one
			// subtraction wraps the write address.
			sum = (CNT_W + 1)'(rp_q[c]) + (CNT_W + 1)'(fill_q[c]);
			if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
				sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
			end
			waddr[c] = PTR_W'(sum);

			if (push_c[c]) begin
				fill_step[c] = fill_q[c] + 1'b1;
			end else if (pop_c[c]) begin
				fill_step[c] = fill_q[c] - 1'b1;
			end else if (clr_c[c]) begin
				fill_step[c] = '0;
			end else begin
				fill_step[c] = fill_q[c];
			end
		end
	end

	// Result of the command being taken.
	always_comb begin
		res_nxt.status    = ST_OK;
		res_nxt.acc       = '0;
		res_nxt.ovf       = '0;
		res_nxt.level     = '0;
		res_nxt.pop_ok    = 1'b0;
		res_nxt.rd_client = cl_idx;
		if (is_frame) begin
			res_nxt.acc = push_c;
			res_nxt.ovf = drop_c;
			if (cmd.in_range) begin
				res_nxt.level = fill_step[cl_idx];
			end
		end else if (!cmd.client_ok) begin
			res_nxt.status = ST_BAD_CLIENT;
		end else begin
			res_nxt.level = fill_step[cl_idx];
			case (cmd.kind)
				KIND_POP: begin
					if (fill_q[cl_idx] == '0) begin
						res_nxt.status = ST_EMPTY;
					end else begin
						res_nxt.pop_ok = 1'b1;
					end
				end
				KIND_STATUS: begin
					res_nxt.status = ovf_flag_q[cl_idx] ? ST_OVERFLOW : ST_OK;
				end
				default: ;
			endcase
		end
	end

	// One frame memory per client, so a received frame lands in all its queues at once.
	for (genvar g = 0; g < NUM_CLIENTS; g++) begin : g_queue
		frame_t mem_q [QUEUE_DEPTH];

		always_ff @(posedge clk) begin
			if (push_c[g]) begin
				mem_q[waddr[g]] <= cmd.frame;
			end
		end

		always_ff @(posedge clk) begin
			if (pop_c[g]) begin
				rdata_q[g] <= mem_q[rp_q[g]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CLIENTS; c++) begin
				fill_q[c]     <= '0;
				rp_q[c]       <= '0;
				ovf_flag_q[c] <= 1'b0;
			end
		end else begin
			for (int c = 0; c < NUM_CLIENTS; c++) begin
				if (limits_upd.wr) begin
					// Lowering a limit drops the newest frames, keeping the oldest.
					if (fill_q[c] > limit_of(limits_upd.value, c)) begin
						fill_q[c] <= limit_of(limits_upd.value, c);
					end
				end else begin
					fill_q[c] <= fill_step[c];
				end
				if (pop_c[c]) begin
					rp_q[c] <= (rp_q[c] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_q[c] + 1'b1;
				end
				if (drop_c[c]) begin
					ovf_flag_q[c] <= 1'b1;
				end else if (push_c[c] || rdst_c[c]) begin
					ovf_flag_q[c] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (cmd_take) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				s2_valid_q <= 1'b1;
			end else if (pop) begin
				s2_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			res_s1 <= res_nxt;
		end
		if (advance) begin
			res_s2   <= res_s1;
			frame_s2 <= res_s1.pop_ok ? rdata_q[res_s1.rd_client] : '0;
		end
	end

	assign empty         = !s2_valid_q;
	assign status        = res_s2.status;
	assign accepted_mask = MASK_W'(res_s2.acc);
	assign overflow_mask = MASK_W'(res_s2.ovf);
	assign queue_level   = LEVEL_W'(res_s2.level);
	assign out_id        = frame_s2.id;
	assign out_ext       = frame_s2.ext;
	assign out_rtr       = frame_s2.rtr;
	assign out_dlc       = frame_s2.dlc;
	assign out_data      = frame_s2.data;

endmodule

`default_nettype wire
